// ===== sv/dlpom_pkg.sv =====
// ============================================================================
// dlpom_pkg - shared constants and types for the low-pulse occupancy meter
// Sizes, register and command codes, reset values and sequencer states.
// ============================================================================
package dlpom_pkg;

	localparam int HISTORY_DEPTH = 8;
	localparam int CHANNELS      = 2;

	localparam int WIN_W   = 20;
	localparam int LEN_W   = 16;
	localparam int COEFF_W = 8;
	localparam int RATIO_W = 15;
	localparam int USED_OUT_W = 4;

	localparam int SLOT_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int USED_W  = $clog2(HISTORY_DEPTH + 1);
	localparam int M_W     = USED_W + COEFF_W;           // windows * coeff
	localparam int DEN_W   = WIN_W + M_W;                // full divisor
	localparam int SUM_W   = WIN_W + $clog2(HISTORY_DEPTH);
	localparam int NUM_W   = SUM_W + RATIO_W;            // sum * 25600
	localparam int REM_W   = DEN_W + 1;
	localparam int CNT_W   = $clog2(NUM_W + 1);

	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	localparam logic [RATIO_W-1:0] RATIO_FULL = RATIO_W'(25600);
	localparam logic [WIN_W-1:0]   TOTAL_MAX  = {WIN_W{1'b1}};
	localparam logic [LEN_W-1:0]   LEN_MAX    = {LEN_W{1'b1}};

	localparam logic [WIN_W-1:0]   WINDOW_RST = WIN_W'(30000);
	localparam logic [LEN_W-1:0]   MIN_RST    = LEN_W'(10);
	localparam logic [LEN_W-1:0]   MAX_RST    = LEN_W'(90);
	localparam logic [COEFF_W-1:0] COEFF_RST  = COEFF_W'(1);

	typedef enum logic [1:0] {
		REG_WINDOW,
		REG_MIN_PULSE,
		REG_MAX_PULSE,
		REG_COEFF
	} reg_idx_t;

	typedef enum logic {
		CMD_TICK    = 1'b0,
		CMD_RESTART = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_MUL,
		ST_DIV_INIT,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

// ===== sv/dlpom_if.sv =====
// ============================================================================
// dlpom channel interfaces - tick input and ratio result streams
// valid/ready handshake; a transfer happens when both are high at clk.
// ============================================================================
interface dlpom_in_if;
	logic valid;
	logic ready;
	logic command;
	logic level_coarse;
	logic level_fine;

	modport source (output valid, output command, output level_coarse,
		output level_fine, input ready);
	modport sink (input valid, input command, input level_coarse,
		input level_fine, output ready);
endinterface

interface dlpom_out_if;
	logic valid;
	logic ready;
	logic [dlpom_pkg::RATIO_W-1:0]    ratio_coarse_q8;
	logic [dlpom_pkg::RATIO_W-1:0]    ratio_fine_q8;
	logic [dlpom_pkg::USED_OUT_W-1:0] windows_used;

	modport source (output valid, output ratio_coarse_q8, output ratio_fine_q8,
		output windows_used, input ready);
	modport sink (input valid, input ratio_coarse_q8, input ratio_fine_q8,
		input windows_used, output ready);
endinterface

// ===== sv/dual_low_pulse_occupancy_meter.sv =====
// ============================================================================
// dual_low_pulse_occupancy_meter - dust sensor low-pulse occupancy ratios
// Per-channel pulse timing, moving-average ring and bit-serial ratio divide.
// ============================================================================
// A tick that does not close a window, or a restart, leaves the block idle.
// A tick that closes a window runs a sequence before a valid result: ring
// update, shift-add multiply for the divisor one multiplier bit per cycle,
// then restoring divide one quotient bit per cycle, then a wait for the
// result register to free up. Input is not taken during that sequence.
// Reset (arst_n low, async): registers to defaults, control state cleared.
// ============================================================================
module dual_low_pulse_occupancy_meter (
	input  logic clk,
	input  logic arst_n,
	dlpom_in_if.sink    in_ch,
	dlpom_out_if.source out_ch,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [dlpom_pkg::ADDR_W-1:0]   paddr,
	input  logic [dlpom_pkg::DATA_W-1:0]   pwdata,
	output logic [dlpom_pkg::DATA_W-1:0]   prdata,
	output logic                           pready
);

	localparam int D  = dlpom_pkg::HISTORY_DEPTH;
	localparam int CH = dlpom_pkg::CHANNELS;

	// ---------------------------------------------------------------- config
	logic [dlpom_pkg::WIN_W-1:0]   window_q;
	logic [dlpom_pkg::LEN_W-1:0]   min_pulse_q;
	logic [dlpom_pkg::LEN_W-1:0]   max_pulse_q;
	logic [dlpom_pkg::COEFF_W-1:0] coeff_q;
	dlpom_pkg::reg_idx_t           reg_idx;
	logic                          cfg_wr;

	assign reg_idx = dlpom_pkg::reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= dlpom_pkg::WINDOW_RST;
			min_pulse_q <= dlpom_pkg::MIN_RST;
			max_pulse_q <= dlpom_pkg::MAX_RST;
			coeff_q     <= dlpom_pkg::COEFF_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				dlpom_pkg::REG_WINDOW:    window_q    <= pwdata[dlpom_pkg::WIN_W-1:0];
				dlpom_pkg::REG_MIN_PULSE: min_pulse_q <= pwdata[dlpom_pkg::LEN_W-1:0];
				dlpom_pkg::REG_MAX_PULSE: max_pulse_q <= pwdata[dlpom_pkg::LEN_W-1:0];
				dlpom_pkg::REG_COEFF:     coeff_q     <= pwdata[dlpom_pkg::COEFF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			dlpom_pkg::REG_WINDOW:    prdata = dlpom_pkg::DATA_W'(window_q);
			dlpom_pkg::REG_MIN_PULSE: prdata = dlpom_pkg::DATA_W'(min_pulse_q);
			dlpom_pkg::REG_MAX_PULSE: prdata = dlpom_pkg::DATA_W'(max_pulse_q);
			dlpom_pkg::REG_COEFF:     prdata = dlpom_pkg::DATA_W'(coeff_q);
			default:                  prdata = '0;
		endcase
	end

	// zero window / zero divisor behave as one
	logic [dlpom_pkg::WIN_W-1:0]   win_eff;
	logic [dlpom_pkg::COEFF_W-1:0] coeff_eff;
	assign win_eff   = (window_q == '0) ? dlpom_pkg::WIN_W'(1) : window_q;
	assign coeff_eff = (coeff_q == '0) ? dlpom_pkg::COEFF_W'(1) : coeff_q;

	// ------------------------------------------------------------- sequencer
	dlpom_pkg::state_t state_q, state_d;
	logic [dlpom_pkg::CNT_W-1:0] cnt_q;
	logic in_accept, tick_go, win_close, out_load;
	logic out_valid_q;

	assign in_accept = in_ch.valid && in_ch.ready;
	assign tick_go   = in_accept && (in_ch.command == dlpom_pkg::CMD_TICK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= dlpom_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d     = state_q;
		in_ch.ready = 1'b0;
		out_load    = 1'b0;
		case (state_q)
			dlpom_pkg::ST_IDLE: begin
				in_ch.ready = 1'b1;
				if (tick_go && win_close) state_d = dlpom_pkg::ST_SUM;
			end
			dlpom_pkg::ST_SUM: state_d = dlpom_pkg::ST_MUL;
			dlpom_pkg::ST_MUL: begin
				if (cnt_q == '0) state_d = dlpom_pkg::ST_DIV_INIT;
			end
			dlpom_pkg::ST_DIV_INIT: state_d = dlpom_pkg::ST_DIV;
			dlpom_pkg::ST_DIV: begin
				if (cnt_q == '0) state_d = dlpom_pkg::ST_DONE;
			end
			dlpom_pkg::ST_DONE: begin
				// wait for the result register to free up
				if (!out_valid_q || out_ch.ready) begin
					out_load = 1'b1;
					state_d  = dlpom_pkg::ST_IDLE;
				end
			end
			default: state_d = dlpom_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (state_q)
				dlpom_pkg::ST_SUM:      cnt_q <= dlpom_pkg::CNT_W'(dlpom_pkg::M_W - 1);
				dlpom_pkg::ST_DIV_INIT: cnt_q <= dlpom_pkg::CNT_W'(dlpom_pkg::NUM_W - 1);
				dlpom_pkg::ST_MUL,
				dlpom_pkg::ST_DIV:      cnt_q <= cnt_q - 1'b1;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------- window timer
	logic [dlpom_pkg::WIN_W-1:0] ticks_q, ticks_inc;
	assign ticks_inc = (ticks_q == dlpom_pkg::TOTAL_MAX) ? ticks_q : ticks_q + 1'b1;
	assign win_close = (ticks_inc >= win_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= '0;
		end else if (in_accept) begin
			if ((in_ch.command == dlpom_pkg::CMD_RESTART) || win_close) ticks_q <= '0;
			else                                                        ticks_q <= ticks_inc;
		end
	end

	// ------------------------------------------------------- ring bookkeeping
	logic [dlpom_pkg::USED_W-1:0] filled_q, filled_nx;
	logic [dlpom_pkg::SLOT_W-1:0] slot_q;
	logic                         ring_full;

	assign ring_full = (filled_q == dlpom_pkg::USED_W'(D));
	assign filled_nx = ring_full ? filled_q : filled_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q <= '0;
			slot_q   <= '0;
		end else if (state_q == dlpom_pkg::ST_SUM) begin
			filled_q <= filled_nx;
			slot_q   <= (slot_q == dlpom_pkg::SLOT_W'(D - 1)) ? '0 : slot_q + 1'b1;
		end
	end

	// -------------------------------------------------- divisor, shift-add
	// den = win * (windows * coeff), one multiplier bit per cycle
	logic [dlpom_pkg::DEN_W-1:0] den_q, mcand_q;
	logic [dlpom_pkg::M_W-1:0]   mplier_q;

	always_ff @(posedge clk) begin
		case (state_q)
			dlpom_pkg::ST_SUM: begin
				den_q    <= '0;
				mcand_q  <= dlpom_pkg::DEN_W'(win_eff);
				mplier_q <= dlpom_pkg::M_W'(filled_nx) * dlpom_pkg::M_W'(coeff_eff);
			end
			dlpom_pkg::ST_MUL: begin
				if (mplier_q[0]) den_q <= den_q + mcand_q;
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
			end
			default: ;
		endcase
	end

	// ----------------------------------------------------------- channels
	logic                             lvl     [CH];
	logic [dlpom_pkg::RATIO_W-1:0]    ratio_q [CH];

	for (genvar c = 0; c < CH; c++) begin : g_lane
		logic                          active_q;
		logic [dlpom_pkg::LEN_W-1:0]   len_q, len_inc;
		logic [dlpom_pkg::WIN_W-1:0]   total_q, total_add;
		logic [dlpom_pkg::WIN_W:0]     total_wide;
		logic                          counted;
		logic [dlpom_pkg::SUM_W-1:0]   sum_q;
		logic [dlpom_pkg::WIN_W-1:0]   ring_q [D];
		logic [dlpom_pkg::WIN_W-1:0]   ring_rd_q, ring_old;
		logic [dlpom_pkg::NUM_W-1:0]   num_q, num_init;
		logic [dlpom_pkg::DEN_W-1:0]   rem_q;
		logic [dlpom_pkg::REM_W-1:0]   rem_sh, rem_sub;
		logic                          q_bit;
		logic [dlpom_pkg::RATIO_W-1:0] quo_q;
		logic                          ovf_q;

		if (c == 0) begin : g_pin0
			assign lvl[c] = in_ch.level_coarse;
		end else if (c == 1) begin : g_pin1
			assign lvl[c] = in_ch.level_fine;
		end else begin : g_pin_none
			assign lvl[c] = 1'b1;
		end

		// pulse timing: length counts every tick after the first low one,
		// the release tick included
		assign len_inc    = (len_q == dlpom_pkg::LEN_MAX) ? len_q : len_q + 1'b1;
		assign counted    = (len_inc >= min_pulse_q) && (len_inc <= max_pulse_q);
		assign total_wide = {1'b0, total_q} + (dlpom_pkg::WIN_W + 1)'(len_inc);
		assign total_add  = total_wide[dlpom_pkg::WIN_W] ? dlpom_pkg::TOTAL_MAX :
			total_wide[dlpom_pkg::WIN_W-1:0];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				active_q <= 1'b0;
				len_q    <= '0;
				total_q  <= '0;
			end else if (tick_go) begin
				if (!active_q) begin
					if (!lvl[c]) begin
						active_q <= 1'b1;
						len_q    <= '0;
					end
				end else if (!lvl[c]) begin
					len_q <= len_inc;
				end else begin
					if (counted) total_q <= total_add;
					active_q <= 1'b0;
					len_q    <= '0;
				end
			end else if (state_q == dlpom_pkg::ST_SUM) begin
				total_q <= '0;
			end
		end

		// history ring: slots past the fill count were never written
		always_ff @(posedge clk) begin
			ring_rd_q <= ring_q[slot_q];
			if (state_q == dlpom_pkg::ST_SUM) ring_q[slot_q] <= total_q;
		end

		assign ring_old = ring_full ? ring_rd_q : '0;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sum_q <= '0;
			end else if (state_q == dlpom_pkg::ST_SUM) begin
				sum_q <= sum_q - dlpom_pkg::SUM_W'(ring_old) + dlpom_pkg::SUM_W'(total_q);
			end
		end

		// numerator sum * 25600 = (sum * (64 + 32 + 4)) << 8
		assign num_init = (dlpom_pkg::NUM_W'(sum_q) << 14) +
			(dlpom_pkg::NUM_W'(sum_q) << 13) + (dlpom_pkg::NUM_W'(sum_q) << 10);

		// restoring divide, one quotient bit per cycle; bits above the
		// result width only set the overflow flag
		assign rem_sh  = {rem_q, num_q[dlpom_pkg::NUM_W-1]};
		assign q_bit   = (rem_sh >= {1'b0, den_q});
		assign rem_sub = q_bit ? rem_sh - {1'b0, den_q} : rem_sh;

		always_ff @(posedge clk) begin
			case (state_q)
				dlpom_pkg::ST_DIV_INIT: begin
					num_q <= num_init;
					rem_q <= '0;
					quo_q <= '0;
					ovf_q <= 1'b0;
				end
				dlpom_pkg::ST_DIV: begin
					num_q <= num_q << 1;
					rem_q <= rem_sub[dlpom_pkg::DEN_W-1:0];
					quo_q <= {quo_q[dlpom_pkg::RATIO_W-2:0], q_bit};
					ovf_q <= ovf_q | quo_q[dlpom_pkg::RATIO_W-1];
				end
				default: ;
			endcase
		end

		always_ff @(posedge clk) begin
			if (out_load) begin
				ratio_q[c] <= (ovf_q || (quo_q > dlpom_pkg::RATIO_FULL)) ?
					dlpom_pkg::RATIO_FULL : quo_q;
			end
		end
	end

	// ------------------------------------------------------- result register
	logic [dlpom_pkg::USED_OUT_W-1:0] used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) used_q <= dlpom_pkg::USED_OUT_W'(filled_q);
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.ratio_coarse_q8 = ratio_q[0];
	assign out_ch.windows_used    = used_q;

	if (CH > 1) begin : g_fine_out
		assign out_ch.ratio_fine_q8 = ratio_q[1];
	end else begin : g_fine_none
		assign out_ch.ratio_fine_q8 = '0;
	end

endmodule

// ===== sv/dlpom_checker.sv =====
// ============================================================================
// dlpom_checker - port-level checks for the occupancy meter
// Result ranges, result hold under backpressure, no result off a transfer.
// ============================================================================
module dlpom_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic [dlpom_pkg::RATIO_W-1:0]       ratio_coarse_q8,
	input logic [dlpom_pkg::RATIO_W-1:0]       ratio_fine_q8,
	input logic [dlpom_pkg::USED_OUT_W-1:0]    windows_used
);

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(ratio_coarse_q8) &&
		$stable(ratio_fine_q8) && $stable(windows_used))
		else $error("result changed while stalled");

	// ratios are saturated at full scale
	a_ratio_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (ratio_coarse_q8 <= dlpom_pkg::RATIO_FULL) &&
		(ratio_fine_q8 <= dlpom_pkg::RATIO_FULL))
		else $error("ratio above full scale");

	// at least one window, at most the ring depth
	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (windows_used != '0) &&
		(windows_used <= dlpom_pkg::USED_OUT_W'(dlpom_pkg::HISTORY_DEPTH)))
		else $error("windows_used out of range");

	// a new result comes from the serial divide, never straight off a transfer
	a_rise_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_valid && in_ready))
		else $error("result raised right after an input transfer");

endmodule

bind dual_low_pulse_occupancy_meter dlpom_checker u_dlpom_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_ch.valid),
	.in_ready        (in_ch.ready),
	.out_valid       (out_ch.valid),
	.out_ready       (out_ch.ready),
	.ratio_coarse_q8 (out_ch.ratio_coarse_q8),
	.ratio_fine_q8   (out_ch.ratio_fine_q8),
	.windows_used    (out_ch.windows_used)
);

// ===== test/dual_low_pulse_occupancy_meter_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dual_low_pulse_occupancy_meter_tb - self-checking bench for the dust meter
// Streams millisecond ticks and window restarts into the block, mirrors the
// pulse timing, the moving-average ring and the Q8 ratio math in a local
// model, and checks every ratio transfer and every register readback.
// ============================================================================
module dual_low_pulse_occupancy_meter_tb;

	// Ticks that close no window leave the block idle; a closing tick runs the
	// ring update, multiply and divide. Settle beyond that before touching regs.
	localparam int SETTLE_CYCLES = 64;
	// No transfer of any kind for this long means the block is stuck. The
	// slowest legal gap is the long receiver hold plus one ratio divide.
	localparam int STALL_LIMIT = 5000;
	localparam int SINK_HOLD_CYCLES = 600;
	localparam int REPORT_MAX = 10;
	localparam longint unsigned Q8_FULL = 25600;

	typedef struct packed {
		dlpom_pkg::cmd_t command;
		logic level_coarse;
		logic level_fine;
	} tick_t;

	typedef struct packed {
		logic [dlpom_pkg::RATIO_W-1:0]    coarse;
		logic [dlpom_pkg::RATIO_W-1:0]    fine;
		logic [dlpom_pkg::USED_OUT_W-1:0] used;
	} ratios_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [dlpom_pkg::ADDR_W-1:0] paddr;
	logic [dlpom_pkg::DATA_W-1:0] pwdata;
	logic [dlpom_pkg::DATA_W-1:0] prdata;
	logic pready;

	dlpom_in_if  tick_if ();
	dlpom_out_if ratio_if ();

	dual_low_pulse_occupancy_meter DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (tick_if),
		.out_ch  (ratio_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// ------------------------------------------------------------------
	// Local copy of the register file, written when an APB write lands.
	// ------------------------------------------------------------------
	logic [dlpom_pkg::WIN_W-1:0]   cfg_window;
	logic [dlpom_pkg::LEN_W-1:0]   cfg_min;
	logic [dlpom_pkg::LEN_W-1:0]   cfg_max;
	logic [dlpom_pkg::COEFF_W-1:0] cfg_coeff;

	// Mirror of the meter state: pulse trackers, open window, history ring.
	logic                         pulse_low     [dlpom_pkg::CHANNELS];
	logic [dlpom_pkg::LEN_W-1:0]  pulse_ticks   [dlpom_pkg::CHANNELS];
	logic [dlpom_pkg::WIN_W-1:0]  window_total  [dlpom_pkg::CHANNELS];
	logic [dlpom_pkg::WIN_W-1:0]  elapsed_ticks;
	logic [dlpom_pkg::WIN_W-1:0]  history
		[dlpom_pkg::CHANNELS][dlpom_pkg::HISTORY_DEPTH];
	logic [dlpom_pkg::SUM_W-1:0]  history_total [dlpom_pkg::CHANNELS];
	logic [dlpom_pkg::USED_W-1:0] windows_filled;
	logic [dlpom_pkg::SLOT_W-1:0] history_slot;

	// Bench bookkeeping.
	tick_t   pending_ticks[$];
	ratios_t expected_ratios[$];
	int unsigned items_queued   = 0;
	int unsigned items_offered  = 0;
	int unsigned items_accepted = 0;
	int unsigned mismatches     = 0;
	int unsigned stall_cycles   = 0;
	logic in_taken       = 1'b0;
	bit   calm           = 1'b0;  // no idling on either side
	bit   sender_pause   = 1'b0;
	bit   want_sink_hold = 1'b0;
	bit   sink_hold_done = 1'b0;
	int unsigned hold_left = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void flag_mismatch(input string msg);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("mismatch at %0t: %s", $time, msg);
	endfunction

	// ------------------------------------------------------------------
	// Occupancy model: advances the mirror by one accepted item. Returns 1
	// and fills r when the item is a tick that closes the window.
	// ------------------------------------------------------------------
	function automatic bit predict_ratios(input tick_t t, output ratios_t r);
		logic level;
		logic [dlpom_pkg::WIN_W:0] grown;
		logic [dlpom_pkg::WIN_W-1:0] win;
		logic [dlpom_pkg::COEFF_W-1:0] coeff;
		longint unsigned q [2];
		longint unsigned den;
		int ch;

		r = '0;
		q[0] = 0;
		q[1] = 0;
		// restart clears only the window timer; pin levels are don't-care
		if (t.command == dlpom_pkg::CMD_RESTART) begin
			elapsed_ticks = '0;
			return 1'b0;
		end

		// pulses first, then the window timer
		for (ch = 0; ch < dlpom_pkg::CHANNELS; ch++) begin
			level = (ch == 0) ? t.level_coarse : (ch == 1) ? t.level_fine : 1'b1;
			if (!pulse_low[ch]) begin
				if (!level) begin
					pulse_low[ch]   = 1'b1;
					pulse_ticks[ch] = '0;
				end
			end else begin
				// the release tick counts too; length sticks at all ones
				if (pulse_ticks[ch] != dlpom_pkg::LEN_MAX)
					pulse_ticks[ch] = pulse_ticks[ch] + 1'b1;
				if (level) begin
					// crossed limits (min > max) never pass this test
					if (pulse_ticks[ch] >= cfg_min && pulse_ticks[ch] <= cfg_max) begin
						grown = {1'b0, window_total[ch]} + pulse_ticks[ch];
						window_total[ch] = (grown > dlpom_pkg::TOTAL_MAX) ?
							dlpom_pkg::TOTAL_MAX : grown[dlpom_pkg::WIN_W-1:0];
					end
					pulse_low[ch]   = 1'b0;
					pulse_ticks[ch] = '0;
				end
			end
		end

		win = (cfg_window == '0) ? dlpom_pkg::WIN_W'(1) : cfg_window;
		if (elapsed_ticks != dlpom_pkg::TOTAL_MAX)
			elapsed_ticks = elapsed_ticks + 1'b1;
		if (elapsed_ticks < win)
			return 1'b0;
		elapsed_ticks = '0;

		if (windows_filled < dlpom_pkg::HISTORY_DEPTH)
			windows_filled = windows_filled + 1'b1;
		coeff = (cfg_coeff == '0) ? dlpom_pkg::COEFF_W'(1) : cfg_coeff;
		den = longint'(win) * longint'(windows_filled) * longint'(coeff);
		for (ch = 0; ch < dlpom_pkg::CHANNELS; ch++) begin
			history_total[ch] = history_total[ch] - history[ch][history_slot]
				+ window_total[ch];
			history[ch][history_slot] = window_total[ch];
			window_total[ch] = '0;
			if (ch < 2) begin
				q[ch] = longint'(history_total[ch]) * Q8_FULL / den;
				if (q[ch] > Q8_FULL)
					q[ch] = Q8_FULL;
			end
		end
		history_slot = (history_slot == dlpom_pkg::SLOT_W'(dlpom_pkg::HISTORY_DEPTH - 1)) ?
			'0 : history_slot + 1'b1;

		r.coarse = q[0][dlpom_pkg::RATIO_W-1:0];
		r.fine   = q[1][dlpom_pkg::RATIO_W-1:0];
		r.used   = windows_filled[dlpom_pkg::USED_OUT_W-1:0];
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Tick driver: pops the next item at the falling edge, holds it until
	// the transfer, idles at random unless calm or paused.
	// ------------------------------------------------------------------
	always @(negedge clk) begin : sender
		tick_t nxt;
		if (!arst_n) begin
			tick_if.valid <= 1'b0;
		end else if (!tick_if.valid || in_taken) begin
			if (pending_ticks.size() != 0 && !sender_pause
				&& (calm || $urandom_range(99) >= 24)) begin
				nxt = pending_ticks.pop_front();
				items_offered++;
				tick_if.valid        <= 1'b1;
				tick_if.command      <= nxt.command;
				tick_if.level_coarse <= nxt.level_coarse;
				tick_if.level_fine   <= nxt.level_fine;
			end else begin
				// junk payload while idle; the block must ignore it
				tick_if.valid        <= 1'b0;
				tick_if.command      <= 1'($urandom_range(1));
				tick_if.level_coarse <= 1'($urandom_range(1));
				tick_if.level_fine   <= 1'($urandom_range(1));
			end
		end
	end

	// Ratio receiver: random back-pressure plus one long hold-off that
	// fills the block and stalls its tick input.
	always @(negedge clk) begin : receiver
		if (!arst_n) begin
			ratio_if.ready <= 1'b0;
		end else if (hold_left != 0) begin
			ratio_if.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (want_sink_hold && !sink_hold_done) begin
			ratio_if.ready <= 1'b0;
			hold_left <= SINK_HOLD_CYCLES;
			sink_hold_done <= 1'b1;
		end else begin
			ratio_if.ready <= calm || ($urandom_range(99) >= 24);
		end
	end

	// ------------------------------------------------------------------
	// Monitor: every tick transfer runs through the model, every ratio
	// transfer is checked against the oldest expectation.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		tick_t   item;
		ratios_t fresh;
		ratios_t oldest;
		ratios_t got;
		if (arst_n) begin
			in_taken <= tick_if.valid && tick_if.ready;
			if (tick_if.valid && tick_if.ready) begin
				items_accepted++;
				item.command      = dlpom_pkg::cmd_t'(tick_if.command);
				item.level_coarse = tick_if.level_coarse;
				item.level_fine   = tick_if.level_fine;
				if (predict_ratios(item, fresh))
					expected_ratios.push_back(fresh);
			end
			if (ratio_if.valid && ratio_if.ready) begin
				got.coarse = ratio_if.ratio_coarse_q8;
				got.fine   = ratio_if.ratio_fine_q8;
				got.used   = ratio_if.windows_used;
				if (expected_ratios.size() == 0) begin
					flag_mismatch($sformatf("result with none pending: coarse %0d fine %0d used %0d",
						got.coarse, got.fine, got.used));
				end else begin
					oldest = expected_ratios.pop_front();
					if (got.coarse !== oldest.coarse || got.fine !== oldest.fine
						|| got.used !== oldest.used)
						flag_mismatch($sformatf(
							"expected coarse %0d fine %0d used %0d, got coarse %0d fine %0d used %0d",
							oldest.coarse, oldest.fine, oldest.used,
							got.coarse, got.fine, got.used));
				end
			end
		end
	end

	// Watchdog: APB accesses count as activity, so config phases are safe.
	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((tick_if.valid && tick_if.ready) || (ratio_if.valid && ratio_if.ready)
				|| (psel && penable)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("FAIL dual_low_pulse_occupancy_meter");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic queue_item(input dlpom_pkg::cmd_t cmd, input logic lc, input logic lf);
		tick_t t;
		t.command      = cmd;
		t.level_coarse = lc;
		t.level_fine   = lf;
		pending_ticks.push_back(t);
		items_queued++;
	endtask

	task automatic queue_ticks(input int unsigned n, input logic lc, input logic lf);
		repeat (n) queue_item(dlpom_pkg::CMD_TICK, lc, lf);
	endtask

	// Pin traffic: alternating low/high runs of random length per channel,
	// a little glitch noise and the odd window restart.
	task automatic queue_traffic(input int unsigned count, input int unsigned max_run);
		bit lvl [2];
		int unsigned run [2];
		int unsigned i;
		int unsigned ch;
		logic lc;
		logic lf;
		for (ch = 0; ch < 2; ch++) begin
			lvl[ch] = 1'($urandom_range(1));
			run[ch] = $urandom_range(max_run, 1);
		end
		for (i = 0; i < count; i++) begin
			if ($urandom_range(99) < 3) begin
				queue_item(dlpom_pkg::CMD_RESTART, 1'($urandom_range(1)),
					1'($urandom_range(1)));
			end else begin
				for (ch = 0; ch < 2; ch++) begin
					if (run[ch] == 0) begin
						lvl[ch] = ~lvl[ch];
						run[ch] = $urandom_range(max_run, 1);
					end
					run[ch]--;
				end
				lc = lvl[0] ^ ($urandom_range(99) < 4);
				lf = lvl[1] ^ ($urandom_range(99) < 4);
				queue_item(dlpom_pkg::CMD_TICK, lc, lf);
			end
		end
	endtask

	// Wait for every queued tick to transfer and every ratio to drain, then
	// let the block finish any tick that closes no window.
	task automatic wait_quiet();
		do @(negedge clk);
		while (items_accepted != items_queued || expected_ratios.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic check_register(input dlpom_pkg::reg_idx_t idx);
		logic [dlpom_pkg::DATA_W-1:0] want;
		case (idx)
			dlpom_pkg::REG_WINDOW:    want = dlpom_pkg::DATA_W'(cfg_window);
			dlpom_pkg::REG_MIN_PULSE: want = dlpom_pkg::DATA_W'(cfg_min);
			dlpom_pkg::REG_MAX_PULSE: want = dlpom_pkg::DATA_W'(cfg_max);
			dlpom_pkg::REG_COEFF:     want = dlpom_pkg::DATA_W'(cfg_coeff);
			default:                  want = '0;
		endcase
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = dlpom_pkg::ADDR_W'({idx, 2'b00});
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want)
			flag_mismatch($sformatf("%s readback: expected %0d, got %0d",
				idx.name(), want, prdata));
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	task automatic set_register(input dlpom_pkg::reg_idx_t idx,
		input logic [dlpom_pkg::DATA_W-1:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = dlpom_pkg::ADDR_W'({idx, 2'b00});
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		// register lands at this edge
		case (idx)
			dlpom_pkg::REG_WINDOW:    cfg_window = value[dlpom_pkg::WIN_W-1:0];
			dlpom_pkg::REG_MIN_PULSE: cfg_min    = value[dlpom_pkg::LEN_W-1:0];
			dlpom_pkg::REG_MAX_PULSE: cfg_max    = value[dlpom_pkg::LEN_W-1:0];
			dlpom_pkg::REG_COEFF:     cfg_coeff  = value[dlpom_pkg::COEFF_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		check_register(idx);
	endtask

	task automatic configure(input int unsigned win, input int unsigned lo,
		input int unsigned hi, input int unsigned coeff);
		set_register(dlpom_pkg::REG_WINDOW, dlpom_pkg::DATA_W'(win));
		set_register(dlpom_pkg::REG_MIN_PULSE, dlpom_pkg::DATA_W'(lo));
		set_register(dlpom_pkg::REG_MAX_PULSE, dlpom_pkg::DATA_W'(hi));
		set_register(dlpom_pkg::REG_COEFF, dlpom_pkg::DATA_W'(coeff));
		@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin : sequence_main
		int unsigned p;
		int unsigned lo;
		int ch;
		int s;

		// every block input known from time zero
		arst_n  = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		tick_if.valid        = 1'b0;
		tick_if.command      = 1'b0;
		tick_if.level_coarse = 1'b1;
		tick_if.level_fine   = 1'b1;
		ratio_if.ready       = 1'b0;

		cfg_window = dlpom_pkg::WINDOW_RST;
		cfg_min    = dlpom_pkg::MIN_RST;
		cfg_max    = dlpom_pkg::MAX_RST;
		cfg_coeff  = dlpom_pkg::COEFF_RST;
		for (ch = 0; ch < dlpom_pkg::CHANNELS; ch++) begin
			pulse_low[ch]     = 1'b0;
			pulse_ticks[ch]   = '0;
			window_total[ch]  = '0;
			history_total[ch] = '0;
			for (s = 0; s < dlpom_pkg::HISTORY_DEPTH; s++)
				history[ch][s] = '0;
		end
		elapsed_ticks  = '0;
		windows_filled = '0;
		history_slot   = '0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset values of the register file
		check_register(dlpom_pkg::REG_WINDOW);
		check_register(dlpom_pkg::REG_MIN_PULSE);
		check_register(dlpom_pkg::REG_MAX_PULSE);
		check_register(dlpom_pkg::REG_COEFF);

		// Directed: 4-tick windows, pulses of 2..5 counted.
		configure(4, 2, 5, 1);
		queue_ticks(1, 1'b1, 1'b1);
		queue_ticks(1, 1'b0, 1'b1);              // coarse goes low
		queue_ticks(1, 1'b1, 1'b0);              // 1-tick bounce dropped, fine low
		queue_ticks(2, 1'b1, 1'b0);              // window closes with fine mid-pulse
		queue_item(dlpom_pkg::CMD_RESTART, 1'b0, 1'b0); // levels ignored, timer cleared
		queue_ticks(1, 1'b1, 1'b1);              // fine released at length 3
		queue_ticks(7, 1'b0, 1'b0);              // both low across a boundary
		queue_ticks(1, 1'b1, 1'b1);              // length 7 > max, dropped
		queue_ticks(3, 1'b0, 1'b1);
		queue_ticks(1, 1'b1, 1'b1);              // released after the boundary
		queue_ticks(2, 1'b1, 1'b0);
		queue_ticks(1, 1'b0, 1'b1);
		queue_item(dlpom_pkg::CMD_RESTART, 1'b1, 1'b1);
		queue_ticks(4, 1'b1, 1'b1);
		wait_quiet();

		// Zero window and zero divisor act as one; min 0, max all ones.
		configure(0, 0, 32'hFFFF, 0);
		queue_traffic(16, 6);
		wait_quiet();

		// Crossed limits: nothing is ever counted. Largest divisor.
		configure(3, 40, 3, 255);
		queue_traffic(40, 50);
		wait_quiet();

		// Very long windows: no window closes here.
		configure(600000, 1, 20, 2);
		queue_traffic(60, 10);
		wait_quiet();
		set_register(dlpom_pkg::REG_WINDOW, dlpom_pkg::DATA_W'(dlpom_pkg::TOTAL_MAX));
		@(posedge clk);
		queue_traffic(30, 10);
		wait_quiet();

		// Random phases with fresh settings each time.
		for (p = 0; p < 5; p++) begin
			lo = $urandom_range(8);
			configure((p == 0) ? 1 : $urandom_range(24, 2), lo, lo + $urandom_range(20),
				(p == 1) ? 255 : $urandom_range(4, 1));
			queue_traffic(75, 30);
			if (p == 0)
				want_sink_hold = 1'b1;    // a result per tick, receiver stalls
			if (p == 1)
				calm = 1'b1;
			if (p == 2) begin
				// stop mid-stream until every pending ratio has drained
				do @(negedge clk); while (items_accepted + 55 < items_queued);
				@(posedge clk);
				sender_pause = 1'b1;
				do @(negedge clk);
				while (items_accepted != items_offered || expected_ratios.size() != 0);
				@(posedge clk);
				sender_pause = 1'b0;
			end
			wait_quiet();
			calm = 1'b0;
		end

		if (mismatches == 0)
			$display("PASS dual_low_pulse_occupancy_meter");
		else
			$display("FAIL dual_low_pulse_occupancy_meter");
		$finish;
	end

endmodule
